/* sv/assert_macros.svh */
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_ON_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/cidrp_pkg.sv */
package cidrp_pkg;

    localparam int NUMBER_CAPACITY = 15;
    // at least four bits so the masked position and length fields always exist
    localparam int CHAR_POS_W      = ($clog2(NUMBER_CAPACITY) > 4) ? $clog2(NUMBER_CAPACITY) : 4;
    localparam int HDR_LEN         = 5;
    localparam logic [2:0] HDR_LAST = 3'(HDR_LEN - 1);

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_ACCEPT = 8'h41;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [7:0] RING_MAX = 8'hFF;

    // register indexes (paddr[2])
    localparam logic REG_LIMIT_OFF = 1'b0;
    localparam logic REG_LIMIT_ON  = 1'b1;

    localparam logic REQ_BYTE  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_ACCEPT = 2'd1,
        EV_WRONG  = 2'd2,
        EV_RING   = 2'd3
    } t_event;

    typedef enum logic [4:0] {
        PH_HDR_HUNT   = 5'b00001,
        PH_HDR_GATHER = 5'b00010,
        PH_NUM_HUNT   = 5'b00100,
        PH_NUM_DIGITS = 5'b01000,
        PH_WAIT_END   = 5'b10000
    } t_phase;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
        logic       motor_on;
    } t_item;

    typedef struct packed {
        t_phase                  phase;
        logic [CHAR_POS_W-1:0]   char_pos;
        logic                    header_match;
        logic [7:0]              ring_tally;
    } t_state;

    // declared msb first so event_res lands in the lowest bits
    typedef struct packed {
        logic       overflow;
        logic [3:0] number_len;
        logic       number_done;
        logic [3:0] digit_pos;
        logic [7:0] digit;
        logic       digit_valid;
        logic       motor_cmd;
        t_event     event_res;
    } t_result;

    localparam int RESULT_W = $bits(t_result);
    localparam int M_DATA_W = ((RESULT_W + 7) / 8) * 8;

    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h2B;
            3'd1:    c = 8'h43;
            3'd2:    c = 8'h4C;
            3'd3:    c = 8'h49;
            3'd4:    c = 8'h50;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* sv/caller_id_response_parser.sv */
// caller-id response parser: takes one modem byte (or a clear request) per item on the
// s_ stream and returns exactly one result item per input on the m_ stream. an item is
// latched into an input register, the parser state and the result are worked out
// combinationally and land in an output register, so one item per clock is sustained
// while m_tready stays high; the single shared state update is what sets this rate. the
// parser hunts "+CLIP", then streams the caller number from its '+' or '0' up to the
// closing quote (at most 14 characters, extra ones are dropped and flagged), then waits
// for 'A' or line feed. ring limits are written over the apb port at offsets 0 and 4.
module caller_id_response_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // rx_byte[7:0], motor_on[8], zero fill
    input  logic        s_tuser,  // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    // event_res[1:0], motor_cmd[2], digit_valid[3], digit[11:4], digit_pos[15:12],
    // number_done[16], number_len[20:17], overflow[21], zero fill
    output logic [cidrp_pkg::M_DATA_W-1:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cidrp_pkg::*;

    logic       r_in_valid;
    t_item      r_in_item;
    logic       r_out_valid;
    t_result    r_out_result;
    t_state     r_state;
    t_state     n_state;
    t_result    n_result;
    logic [7:0] r_limit_off;
    logic [7:0] r_limit_on;
    logic       advance;
    logic       cfg_wr;

    assign advance  = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_item.req_type <= s_tuser;
            r_in_item.rx_byte  <= s_tdata[7:0];
            r_in_item.motor_on <= s_tdata[8];
        end
    end

    cidrp_core u_core (
        .i_item      (r_in_item),
        .i_state     (r_state),
        .i_limit_off (r_limit_off),
        .i_limit_on  (r_limit_on),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= PH_HDR_HUNT;
            r_state.char_pos     <= '0;
            r_state.header_match <= 1'b1;
            r_state.ring_tally   <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_result <= n_result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = M_DATA_W'(r_out_result);

    // register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_off <= 8'd3;
            r_limit_on  <= 8'd6;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_LIMIT_OFF) begin
                r_limit_off <= pwdata[7:0];
            end else begin
                r_limit_on <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_LIMIT_ON) begin
            prdata = {24'd0, r_limit_on};
        end else begin
            prdata = {24'd0, r_limit_off};
        end
    end

endmodule

/* sv/cidrp_core.sv */
module cidrp_core (
    input  cidrp_pkg::t_item   i_item,
    input  cidrp_pkg::t_state  i_state,
    input  logic [7:0]         i_limit_off,
    input  logic [7:0]         i_limit_on,
    output cidrp_pkg::t_state  o_state,
    output cidrp_pkg::t_result o_result
);
    import cidrp_pkg::*;

    logic [2:0]       hdr_p;
    logic             hdr_ok;
    logic [7:0]       limit;
    t_state           nst;
    t_result          res;

    always_comb begin
        hdr_p  = (i_state.char_pos < CHAR_POS_W'(HDR_LEN)) ? i_state.char_pos[2:0] : HDR_LAST;
        hdr_ok = i_state.header_match && (i_item.rx_byte == hdr_char(hdr_p));
        limit  = i_item.motor_on ? i_limit_on : i_limit_off;

        nst = i_state;
        res = '0;

        if (i_item.req_type == REQ_CLEAR) begin
            nst.ring_tally = '0;
        end else begin
            unique case (i_state.phase)
                PH_HDR_HUNT: begin
                    if (i_item.rx_byte == CH_PLUS) begin
                        nst.phase        = PH_HDR_GATHER;
                        nst.header_match = 1'b1;
                        nst.char_pos     = CHAR_POS_W'(1);
                    end
                end
                PH_HDR_GATHER: begin
                    if (hdr_p == HDR_LAST) begin
                        nst.phase        = hdr_ok ? PH_NUM_HUNT : PH_HDR_HUNT;
                        nst.char_pos     = '0;
                        nst.header_match = 1'b1;
                    end else begin
                        nst.header_match = hdr_ok;
                        nst.char_pos     = CHAR_POS_W'(hdr_p) + CHAR_POS_W'(1);
                    end
                end
                PH_NUM_HUNT: begin
                    if (i_item.rx_byte == CH_PLUS || i_item.rx_byte == CH_ZERO) begin
                        nst.phase       = PH_NUM_DIGITS;
                        nst.char_pos    = CHAR_POS_W'(1);
                        res.digit_valid = 1'b1;
                        res.digit       = i_item.rx_byte;
                    end
                end
                PH_NUM_DIGITS: begin
                    if (i_item.rx_byte == CH_QUOTE) begin
                        res.number_done = 1'b1;
                        res.number_len  = i_state.char_pos[3:0];
                        nst.phase       = PH_WAIT_END;
                        nst.char_pos    = '0;
                    end else if (i_state.char_pos < CHAR_POS_W'(NUMBER_CAPACITY - 1)) begin
                        res.digit_valid = 1'b1;
                        res.digit       = i_item.rx_byte;
                        res.digit_pos   = i_state.char_pos[3:0];
                        nst.char_pos    = i_state.char_pos + CHAR_POS_W'(1);
                    end else begin
                        res.overflow = 1'b1;
                    end
                end
                PH_WAIT_END: begin
                    if (i_item.rx_byte == CH_ACCEPT || i_item.rx_byte == CH_LF) begin
                        nst.phase        = PH_HDR_HUNT;
                        nst.char_pos     = '0;
                        nst.header_match = 1'b1;
                    end
                    if (i_item.rx_byte == CH_ACCEPT) begin
                        if (i_state.ring_tally < limit) begin
                            res.event_res  = EV_ACCEPT;
                            res.motor_cmd  = ~i_item.motor_on;
                            nst.ring_tally = '0;
                        end else begin
                            res.event_res = EV_RING;
                            if (i_state.ring_tally != RING_MAX) begin
                                nst.ring_tally = i_state.ring_tally + 8'd1;
                            end
                        end
                    end else if (i_item.rx_byte == CH_LF) begin
                        res.event_res = EV_WRONG;
                    end
                end
                default: begin
                    nst.phase = PH_HDR_HUNT;
                end
            endcase
        end
    end

    assign o_state  = nst;
    assign o_result = res;

endmodule

/* sv/cidrp_checker.sv */
`include "assert_macros.svh"

module cidrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [cidrp_pkg::M_DATA_W-1:0] m_tdata
);
    import cidrp_pkg::*;

    `ASSERT_ALWAYS(a_idle_after_reset, i_clk, !i_rst_n |=> !m_tvalid, "result shown right after reset")
    `ASSERT_ON_CLK(a_hold_on_stall, i_clk, i_rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    `ASSERT_ON_CLK(a_digit_alone, i_clk, i_rst_n, m_tvalid && m_tdata[3] |-> m_tdata[1:0] == EV_NONE && !m_tdata[16] && !m_tdata[21], "digit mixed with other report")
    `ASSERT_ON_CLK(a_motor_on_accept, i_clk, i_rst_n, m_tvalid && m_tdata[2] |-> m_tdata[1:0] == EV_ACCEPT, "motor command without accepted caller")
    `ASSERT_ON_CLK(a_len_on_done, i_clk, i_rst_n, m_tvalid && !m_tdata[16] |-> m_tdata[20:17] == 4'd0, "number length without closing quote")

endmodule

bind caller_id_response_parser cidrp_checker u_cidrp_checker (.*);

/* sim/tb_caller_id_response_parser.sv */
module tb_caller_id_response_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import cidrp_pkg::*;

    localparam int LIMIT_CYCLES = 1_500_000;

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;  // rx_byte[7:0], motor_on[8], zero fill
    logic        s_tuser  = 1'b0;  // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // event_res[1:0], motor_cmd[2], digit_valid[3], digit[11:4], digit_pos[15:12],
    // number_done[16], number_len[20:17], overflow[21], zero fill
    logic [M_DATA_W-1:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    caller_id_response_parser dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // parser state as seen by the predictor
    logic       hdr_ok;
    logic       num_ok;
    logic       run_open;
    int         run_pos;
    logic       hdr_good;
    logic [7:0] rings    = '0;
    logic [7:0] lim_off  = 8'd3;
    logic [7:0] lim_on   = 8'd6;

    logic [7:0] hdr_text [HDR_LEN] = '{8'h2B, 8'h43, 8'h4C, 8'h49, 8'h50};

    t_item   tx_items [$];
    t_result parsed_q [$];
    int      queued_cnt = 0;
    int      err_cnt    = 0;
    int      cycle_cnt  = 0;
    int      src_wait   = 0;
    int      snk_wait   = 0;
    bit      src_idle   = 1'b1;
    bit      snk_idle   = 1'b1;
    bit      clear_mix  = 1'b0;
    bit      in_taken   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        else if (r < 90) return $urandom_range(1, 3);
        else if (r < 98) return $urandom_range(4, 12);
        else return $urandom_range(20, 40);
    endfunction

    function automatic string result_str(input t_result r);
        return $sformatf("ev=%0d mcmd=%0d dval=%0d dig=%02h pos=%0d done=%0d len=%0d ovf=%0d",
                         r.event_res, r.motor_cmd, r.digit_valid, r.digit, r.digit_pos,
                         r.number_done, r.number_len, r.overflow);
    endfunction

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("%s", msg);
    endtask

    task automatic clear_hunt();
        hdr_ok   = 1'b0;
        num_ok   = 1'b0;
        run_open = 1'b0;
        run_pos  = 0;
        hdr_good = 1'b1;
    endtask

    // one result per item: header hunt, number capture, then accept, ring or wrong number; a clear resets the rings
    task automatic parse_modem_item(input t_item it, output t_result r);
        int         p;
        logic [7:0] lim;
        logic [7:0] b;
        r = '0;
        b = it.rx_byte;
        if (it.req_type == REQ_CLEAR) begin
            rings = '0;
        end else if (!hdr_ok) begin
            if (!run_open) begin
                if (b == CH_PLUS) begin
                    run_open = 1'b1;
                    hdr_good = 1'b1;
                    run_pos  = 1;
                end
            end else begin
                p = (run_pos < HDR_LEN) ? run_pos : HDR_LEN - 1;
                if (b != hdr_text[p]) hdr_good = 1'b0;
                if (p >= HDR_LEN - 1) begin
                    hdr_ok   = hdr_good;
                    run_open = 1'b0;
                    run_pos  = 0;
                    hdr_good = 1'b1;
                end else begin
                    run_pos = p + 1;
                end
            end
        end else if (!num_ok) begin
            if (!run_open) begin
                if (b == CH_PLUS || b == CH_ZERO) begin
                    run_open      = 1'b1;
                    r.digit_valid = 1'b1;
                    r.digit       = b;
                    r.digit_pos   = '0;
                    run_pos       = 1;
                end
            end else if (b == CH_QUOTE) begin
                r.number_done = 1'b1;
                r.number_len  = 4'(run_pos);
                run_open      = 1'b0;
                run_pos       = 0;
                num_ok        = 1'b1;
            end else if (run_pos < NUMBER_CAPACITY - 1) begin
                r.digit_valid = 1'b1;
                r.digit       = b;
                r.digit_pos   = 4'(run_pos);
                run_pos++;
            end else begin
                r.overflow = 1'b1;
            end
        end else begin
            if (b == CH_ACCEPT) begin
                lim = it.motor_on ? lim_on : lim_off;
                if (rings < lim) begin
                    r.event_res = EV_ACCEPT;
                    r.motor_cmd = ~it.motor_on;
                    rings       = '0;
                end else begin
                    r.event_res = EV_RING;
                    if (rings != RING_MAX) rings++;
                end
                clear_hunt();
            end else if (b == CH_LF) begin
                r.event_res = EV_WRONG;
                clear_hunt();
            end
        end
    endtask

    task automatic queue_clear();
        t_item it;
        it.req_type = REQ_CLEAR;
        it.rx_byte  = 8'($urandom);
        it.motor_on = 1'($urandom);
        tx_items.push_back(it);
        queued_cnt++;
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic m);
        t_item it;
        if (clear_mix && $urandom_range(0, 99) < 2) queue_clear();
        it.req_type = REQ_BYTE;
        it.rx_byte  = b;
        it.motor_on = m;
        tx_items.push_back(it);
        queued_cnt++;
    endtask

    task automatic queue_text(input string s, input logic m);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i], m);
    endtask

    // mostly well-formed call reports, some noise bursts and broken headers, or only bare ring calls
    task automatic queue_calls(input int n, input bit bare);
        int         goal;
        int         r;
        int         len;
        int         k;
        logic       m;
        logic [7:0] c;
        goal = queued_cnt + n;
        while (queued_cnt < goal) begin
            m = 1'($urandom);
            if (bare) begin
                queue_text("+CLIP+\"A", m);
            end else if ($urandom_range(0, 99) < 10) begin
                repeat ($urandom_range(3, 10)) queue_byte(8'($urandom), m);
            end else begin
                if ($urandom_range(0, 99) < 20)
                    repeat ($urandom_range(1, 3)) queue_byte(8'($urandom), m);
                if ($urandom_range(0, 99) < 85) begin
                    queue_text("+CLIP", m);
                end else begin
                    k = $urandom_range(1, HDR_LEN - 1);
                    queue_byte(CH_PLUS, m);
                    for (int i = 1; i < HDR_LEN; i++) begin
                        c = hdr_text[i];
                        if (i == k) c = c ^ 8'($urandom_range(1, 255));
                        queue_byte(c, m);
                    end
                end
                if ($urandom_range(0, 99) < 20)
                    repeat ($urandom_range(1, 2)) queue_byte(8'($urandom), m);
                queue_byte($urandom_range(0, 1) ? CH_PLUS : CH_ZERO, m);
                r = $urandom_range(0, 99);
                if (r < 80) len = $urandom_range(0, 13);
                else if (r < 95) len = $urandom_range(14, 18);
                else len = $urandom_range(19, 25);
                repeat (len) begin
                    if ($urandom_range(0, 99) < 85) c = 8'h30 + 8'($urandom_range(0, 9));
                    else c = 8'($urandom);
                    queue_byte(c, m);
                end
                queue_byte(CH_QUOTE, m);
                if ($urandom_range(0, 99) < 15) queue_byte(8'($urandom), m);
                r = $urandom_range(0, 99);
                if (r < 65) queue_byte(CH_ACCEPT, m);
                else if (r < 95) queue_byte(CH_LF, m);
            end
        end
    endtask

    task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_limits(input logic [7:0] off_v, input logic [7:0] on_v);
        logic [31:0] rd;
        apb_xfer(1'b1, {REG_LIMIT_OFF, 2'b00}, {24'($urandom), off_v}, rd);
        lim_off = off_v;
        apb_xfer(1'b1, {REG_LIMIT_ON, 2'b00}, {24'($urandom), on_v}, rd);
        lim_on = on_v;
        apb_xfer(1'b0, {REG_LIMIT_OFF, 2'b00}, 32'h0, rd);
        if (rd[7:0] !== off_v)
            note_error($sformatf("limit_off readback want %02h got %02h", off_v, rd[7:0]));
        apb_xfer(1'b0, {REG_LIMIT_ON, 2'b00}, 32'h0, rd);
        if (rd[7:0] !== on_v)
            note_error($sformatf("limit_on readback want %02h got %02h", on_v, rd[7:0]));
    endtask

    // sender holds off until every pending item has been answered
    task automatic wait_idle();
        @(posedge i_clk);
        while (tx_items.size() != 0 || s_tvalid || parsed_q.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin : drive_items
        t_item it;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (src_wait > 0) begin
                src_wait--;
                s_tvalid <= 1'b0;
            end else if (tx_items.size() != 0) begin
                it = tx_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'b0, it.motor_on, it.rx_byte};
                s_tuser  <= it.req_type;
                if (src_idle) src_wait = gap_len();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : drive_ready
        if (snk_wait > 0) begin
            snk_wait--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (snk_idle) snk_wait = gap_len();
        end
    end

    always @(posedge i_clk) begin : watch_streams
        t_item   acc;
        t_result want;
        t_result got;
        in_taken = i_rst_n && s_tvalid && s_tready;
        if (in_taken) begin
            acc.req_type = s_tuser;
            acc.rx_byte  = s_tdata[7:0];
            acc.motor_on = s_tdata[8];
            parse_modem_item(acc, want);
            parsed_q.push_back(want);
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            got = t_result'(m_tdata[RESULT_W-1:0]);
            if (parsed_q.size() == 0) begin
                note_error($sformatf("unexpected result: %s", result_str(got)));
            end else begin
                want = parsed_q.pop_front();
                if (got.event_res !== want.event_res || got.motor_cmd !== want.motor_cmd ||
                    got.digit_valid !== want.digit_valid || got.digit !== want.digit ||
                    got.digit_pos !== want.digit_pos || got.number_done !== want.number_done ||
                    got.number_len !== want.number_len || got.overflow !== want.overflow)
                    note_error($sformatf("mismatch: want %s / got %s",
                                         result_str(want), result_str(got)));
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        t_item it;
        clear_hunt();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, reset limits still in force
        it.req_type = REQ_CLEAR;
        it.rx_byte  = 8'hFF;
        it.motor_on = 1'b1;
        tx_items.push_back(it);
        queue_byte(8'h00, 1'b0);
        queue_text("+CLIQ", 1'b1);         // header mismatch, hunt restarts
        queue_text("+CLIP", 1'b0);
        queue_byte(8'hFF, 1'b1);           // ignored while hunting the number
        queue_text("+9\"", 1'b0);
        queue_byte("Z", 1'b1);             // ignored while waiting for the end
        queue_byte(CH_ACCEPT, 1'b0);
        queue_text("+CLIP0\"", 1'b1);
        queue_byte(CH_LF, 1'b1);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_limits(8'd0, 8'd255);
                1: set_limits(8'd255, 8'd0);
                2: set_limits(8'd0, 8'd0);
                3: set_limits(8'd255, 8'd255);
                default: set_limits(8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)));
            endcase
            src_idle  = (ph != 4);
            snk_idle  = (ph != 4) && (ph != 5);
            clear_mix = (ph != 2);
            // ring-only calls back to back build up a large ring count
            if (ph == 2) queue_calls(400, 1'b1);
            else queue_calls(140, 1'b0);
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (err_cnt == 0 && parsed_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
